>>> rtl/rational_arithmetic_unit_assert.svh
// Assertion macros used by rational_arithmetic_unit.sv.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTH
// The condition must hold in the same cycle as the trigger.
`define RAU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// The condition must hold in the cycle after the trigger.
`define RAU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RAU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RAU_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

   typedef enum logic [3:0] {
      OP_MAKE = 4'd0,
      OP_ADD  = 4'd1,
      OP_SUB  = 4'd2,
      OP_MUL  = 4'd3,
      OP_DIV  = 4'd4,
      OP_LT   = 4'd5,
      OP_GT   = 4'd6,
      OP_LE   = 4'd7,
      OP_GE   = 4'd8,
      OP_EQ   = 4'd9
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_PREP,
      ST_GCD_GO,
      ST_GCD_WAIT,
      ST_DIVN_GO,
      ST_DIVN_WAIT,
      ST_DIVD_GO,
      ST_DIVD_WAIT,
      ST_FINISH,
      ST_OUT
   } state_type;

   // Status that an iterative unit reports back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage
`default_nettype wire

>>> rtl/rau_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rau_div import rau_pkg::*; #(
   parameter int MW = 64
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [MW-1:0] dividend,
   input  wire logic [MW-1:0] divisor,
   output logic [MW-1:0]      quotient,
   output unit_sts_type       sts
);

   localparam int CW = $clog2(MW);

   logic [MW-1:0] q_ff, q_in;
   logic [MW-1:0] rem_ff, rem_in;
   logic [MW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [MW:0]   rem_sh;
   logic [MW:0]   rem_sub;

   // Restoring division, one quotient bit per cycle. The dividend shifts out
   // of the top of q while quotient bits shift in at the bottom.
   assign rem_sh  = {rem_ff, q_ff[MW-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(MW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sub[MW-1:0];
            q_in   = {q_ff[MW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[MW-1:0];
            q_in   = {q_ff[MW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = q_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule
`default_nettype wire

>>> rtl/rau_gcd.sv
`timescale 1ns / 1ps
`default_nettype none
module rau_gcd import rau_pkg::*; #(
   parameter int MW = 64
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [MW-1:0] x,
   input  wire logic [MW-1:0] y,
   output logic [MW-1:0]      g,
   output unit_sts_type       sts
);

   localparam int KW = $clog2(MW);

   logic [MW-1:0] x_ff, x_in;
   logic [MW-1:0] y_ff, y_in;
   logic [MW-1:0] g_ff, g_in;
   logic [KW-1:0] k_ff, k_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   // Binary gcd: one shift or one subtract per cycle. Common factors of two
   // are counted in k and put back when one operand reaches zero.
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      g_in    = g_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = x;
         y_in    = y;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff == '0 || y_ff == '0) begin
            g_in    = (x_ff | y_ff) << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_in = x_ff - y_ff;
         end else begin
            y_in = y_ff - x_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      g_ff <= g_in;
      k_ff <= k_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign g        = g_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule
`default_nettype wire

>>> rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: one item in, one result item out.
// The request channel carries an opcode in req_tuser and two fractions in
// req_tdata; the response channel returns a normalized fraction, a compare
// flag in rsp_tdata and an overflow flag in rsp_tuser.
// The unit works on one item at a time: req_tready is high only while it is
// idle, and it stays low until the result has been taken.
// Every item first passes the shared multiplier states ST_MUL0, ST_MUL1 and
// ST_MUL2, which form the cross products one after another, and the
// preparation state ST_PREP. Compares and unused opcodes then go straight to
// ST_OUT, which raises rsp_tvalid. Arithmetic items run a binary gcd on the
// 2*WORD_BITS-bit magnitudes (one shift or subtract per cycle) and two
// restoring divisions by the gcd; a 0/0 fraction skips the divisions.
// Items never overlap: a new item is taken only after the result of the
// last one has been taken.
// The result stays on rsp_tdata with rsp_tvalid high for as long as the
// receiver holds rsp_tready low; no new item is taken meanwhile.
// Reset clears the sequencer and both iterative units; the unit comes out
// of reset idle and ready.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit import rau_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,  // a_num, a_den, b_num, b_den, zero pad
   input  wire logic [3:0]   req_tuser,  // opcode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,  // result_num, result_den, compare_true
   output logic [0:0]        rsp_tuser   // overflow
);

   localparam int W  = WORD_BITS;
   localparam int MW = 2 * WORD_BITS;
   localparam logic [MW-1:0] LIM = MW'(1) << (W - 1);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic signed [W-1:0]  an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in;
   logic [W-2:0]         bd_ff, bd_in;
   logic signed [MW-1:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic                 neg_ff, neg_in;
   logic [MW-1:0]        nmag_ff, nmag_in, dmag_ff, dmag_in;
   logic [31:0]          num_ff, num_in;
   logic [30:0]          den_ff, den_in;
   logic                 cmp_ff, cmp_in;
   logic                 ovf_ff, ovf_in;

   logic signed [W-1:0]  mul_x, mul_y;
   logic signed [MW-1:0] prod;
   logic signed [W-1:0]  bd_s;
   logic signed [MW-1:0] nval, dval;
   logic                 adz, bdz, lt_raw, gt_raw, lt_v, gt_v, t_v;
   logic                 neg_eff, ovf_v;
   logic signed [W-1:0]  res_w;

   logic                 gcd_start, div_start;
   logic [MW-1:0]        gcd_g, div_q, div_dividend;
   unit_sts_type         gcd_sts, div_sts;

   assign bd_s = $signed({1'b0, bd_ff});

   // Shared multiplier; its product is registered in p0, p1 or p2.
   always_comb begin
      mul_x = an_ff;
      mul_y = bd_s;
      case (state_ff)
         ST_MUL0: begin
            mul_x = an_ff;
            mul_y = (op_ff == OP_MUL) ? bn_ff : bd_s;
         end
         ST_MUL1: begin
            mul_x = bn_ff;
            mul_y = ad_ff;
         end
         ST_MUL2: begin
            mul_x = ad_ff;
            mul_y = bd_s;
         end
         default: ;
      endcase
   end

   assign prod = mul_x * mul_y;

   // Numerator and denominator before reduction.
   always_comb begin
      case (op_ff)
         OP_MAKE: begin
            nval = MW'(an_ff);
            dval = MW'(ad_ff);
         end
         OP_ADD: begin
            nval = p0_ff + p1_ff;
            dval = p2_ff;
         end
         OP_SUB: begin
            nval = p0_ff - p1_ff;
            dval = p2_ff;
         end
         OP_MUL: begin
            nval = p0_ff;
            dval = p2_ff;
         end
         default: begin
            nval = p0_ff;
            dval = p1_ff;
         end
      endcase
   end

   // Compares work on a_num*b_den against b_num*a_den; a negative a_den flips
   // the order. A zero denominator on either side follows its own rule.
   assign adz    = (ad_ff == '0);
   assign bdz    = (bd_ff == '0);
   assign lt_raw = p0_ff < p1_ff;
   assign gt_raw = p0_ff > p1_ff;
   assign lt_v   = ad_ff[W-1] ? gt_raw : lt_raw;
   assign gt_v   = ad_ff[W-1] ? lt_raw : gt_raw;

   always_comb begin
      t_v = 1'b0;
      case (op_ff)
         OP_LT: t_v = lt_v;
         OP_GT: t_v = gt_v;
         OP_LE: t_v = !gt_v;
         OP_GE: t_v = !lt_v;
         OP_EQ: t_v = (p0_ff == p1_ff);
         default: t_v = 1'b0;
      endcase
      if (op_ff == OP_EQ) begin
         if (adz && bdz) begin
            t_v = ((an_ff == '0) == (bn_ff == '0)) && (an_ff[W-1] == bn_ff[W-1]);
         end else if (adz || bdz) begin
            t_v = 1'b0;
         end
      end else if (adz || bdz) begin
         t_v = adz && bdz;
      end
   end

   assign neg_eff = neg_ff && (nmag_ff != '0);
   assign ovf_v   = (neg_eff ? (nmag_ff > LIM) : (nmag_ff >= LIM)) || (dmag_ff >= LIM);
   assign res_w   = neg_eff ? -$signed(nmag_ff[W-1:0]) : $signed(nmag_ff[W-1:0]);

   assign div_dividend = (state_ff == ST_DIVD_GO) ? dmag_ff : nmag_ff;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      an_in      = an_ff;
      ad_in      = ad_ff;
      bn_in      = bn_ff;
      bd_in      = bd_ff;
      p0_in      = p0_ff;
      p1_in      = p1_ff;
      p2_in      = p2_ff;
      neg_in     = neg_ff;
      nmag_in    = nmag_ff;
      dmag_in    = dmag_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      cmp_in     = cmp_ff;
      ovf_in     = ovf_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      gcd_start  = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in    = op_type'(req_tuser);
               an_in    = req_tdata[W-1:0];
               ad_in    = req_tdata[32+W-1:32];
               bn_in    = req_tdata[64+W-1:64];
               bd_in    = req_tdata[96+W-2:96];
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: begin
            p0_in    = prod;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            p1_in    = prod;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            p2_in    = prod;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            num_in = '0;
            den_in = '0;
            cmp_in = 1'b0;
            ovf_in = 1'b0;
            if (op_ff inside {OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ}) begin
               cmp_in   = t_v;
               state_in = ST_OUT;
            end else if (op_ff inside {OP_MAKE, OP_ADD, OP_SUB, OP_MUL, OP_DIV}) begin
               neg_in   = nval[MW-1] ^ dval[MW-1];
               nmag_in  = nval[MW-1] ? MW'(-nval) : MW'(nval);
               dmag_in  = dval[MW-1] ? MW'(-dval) : MW'(dval);
               state_in = ST_GCD_GO;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_GCD_GO: begin
            gcd_start = 1'b1;
            state_in  = ST_GCD_WAIT;
         end
         ST_GCD_WAIT: begin
            // A zero gcd means 0/0, which is left as it is.
            if (gcd_sts.done) begin
               state_in = (gcd_g == '0) ? ST_FINISH : ST_DIVN_GO;
            end
         end
         ST_DIVN_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIVN_WAIT;
         end
         ST_DIVN_WAIT: begin
            if (div_sts.done) begin
               nmag_in  = div_q;
               state_in = ST_DIVD_GO;
            end
         end
         ST_DIVD_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIVD_WAIT;
         end
         ST_DIVD_WAIT: begin
            if (div_sts.done) begin
               dmag_in  = div_q;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            ovf_in   = ovf_v;
            num_in   = ovf_v ? '0 : 32'(res_w);
            den_in   = ovf_v ? '0 : 31'(dmag_ff);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      an_ff   <= an_in;
      ad_ff   <= ad_in;
      bn_ff   <= bn_in;
      bd_ff   <= bd_in;
      p0_ff   <= p0_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      neg_ff  <= neg_in;
      nmag_ff <= nmag_in;
      dmag_ff <= dmag_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      cmp_ff  <= cmp_in;
      ovf_ff  <= ovf_in;
   end

   rau_gcd #(
      .MW(MW)
   ) u_gcd (
      .clock(clock),
      .reset(reset),
      .start(gcd_start),
      .x(nmag_ff),
      .y(dmag_ff),
      .g(gcd_g),
      .sts(gcd_sts)
   );

   rau_div #(
      .MW(MW)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(div_dividend),
      .divisor(gcd_g),
      .quotient(div_q),
      .sts(div_sts)
   );

   assign rsp_tdata = {cmp_ff, den_ff, num_ff};
   assign rsp_tuser = ovf_ff;

   `RAU_ASSERT_IMP(a_ready_excl, clock, reset, req_tready, !rsp_tvalid)
   `RAU_ASSERT_IMP(a_idle_units, clock, reset, state_ff == ST_IDLE, !gcd_sts.busy && !div_sts.busy)
   `RAU_ASSERT_IMP(a_ovf_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0)
   `RAU_ASSERT_IMP(a_cmp_zero, clock, reset, rsp_tvalid && rsp_tdata[63], rsp_tdata[62:0] == '0 && !rsp_tuser[0])
   `RAU_ASSERT_NXT(a_take_item, clock, reset, req_tvalid && req_tready, state_ff == ST_MUL0)

endmodule
`default_nettype wire

>>> sim/rational_arithmetic_unit_checker.sv
`timescale 1ns / 1ps
module rational_arithmetic_unit_checker import rau_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [127:0] req_tdata,  // a_num, a_den, b_num, b_den, zero pad
   input  wire logic [3:0]   req_tuser,  // opcode
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [63:0]  rsp_tdata,  // result_num, result_den, compare_true
   input  wire logic [0:0]   rsp_tuser,  // overflow
   output int                mismatch_count,
   output int                outstanding
);

   typedef struct packed {
      logic [31:0] num;
      logic [30:0] den;
      logic        cmp;
      logic        ovf;
   } frac_result_type;

   frac_result_type fraction_queue[$];
   int              result_index;

   initial begin
      mismatch_count = 0;
      result_index = 0;
   end

   assign outstanding = fraction_queue.size();

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on result %0d: %s got %h want %h", result_index, what, got, want);
      mismatch_count++;
   endtask

   function automatic bit [63:0] euclid_gcd(input bit [63:0] x, input bit [63:0] y);
      while (x != 0 && y != 0) begin
         if (x > y) x = x % y;
         else y = y % x;
      end
      return x + y;
   endfunction

   function automatic void split_sign(input longint x, output bit neg, output bit [63:0] mag);
      neg = x < 0;
      mag = neg ? 64'(-x) : 64'(x);
   endfunction

   function automatic frac_result_type reduce_fraction(input bit n_neg, input bit [63:0] n_mag,
                                                       input bit d_neg, input bit [63:0] d_mag);
      frac_result_type r;
      bit              neg;
      bit [63:0]       g;
      bit [63:0]       lim;
      neg = n_neg != d_neg;
      lim = 64'h8000_0000;
      g = euclid_gcd(n_mag, d_mag);
      if (g != 0) begin
         n_mag = n_mag / g;
         d_mag = d_mag / g;
      end
      if (n_mag == 0) neg = 0;
      r = '0;
      if ((neg ? n_mag > lim : n_mag >= lim) || d_mag >= lim) begin
         r.ovf = 1'b1;
      end else begin
         r.num = neg ? 32'(-n_mag) : 32'(n_mag);
         r.den = d_mag[30:0];
      end
      return r;
   endfunction

   function automatic frac_result_type reduce_signed(input longint n, input longint d);
      bit        nn, dn;
      bit [63:0] nm, dm;
      split_sign(n, nn, nm);
      split_sign(d, dn, dm);
      return reduce_fraction(nn, nm, dn, dm);
   endfunction

   function automatic frac_result_type predict_fraction(input logic [3:0] op,
                                                        input logic [127:0] data);
      frac_result_type r, ra, rb;
      longint          an, ad, bn, bd, lhs, rhs;
      bit              pn, qn, sn;
      bit [63:0]       pm, qm, sm;
      an = longint'($signed(data[31:0]));
      ad = longint'($signed(data[63:32]));
      bn = longint'($signed(data[95:64]));
      bd = longint'(data[126:96]);
      r = '0;
      case (op)
         OP_MAKE: r = reduce_signed(an, ad);
         OP_ADD, OP_SUB: begin
            lhs = an * bd;
            rhs = (op == OP_ADD) ? bn * ad : -(bn * ad);
            split_sign(lhs, pn, pm);
            split_sign(rhs, qn, qm);
            if (pn == qn) begin
               sn = pn;
               sm = pm + qm;
            end else if (pm >= qm) begin
               sn = pn;
               sm = pm - qm;
            end else begin
               sn = qn;
               sm = qm - pm;
            end
            split_sign(ad * bd, qn, qm);
            r = reduce_fraction(sn, sm, qn, qm);
         end
         OP_MUL: r = reduce_signed(an * bn, ad * bd);
         OP_DIV: r = reduce_signed(an * bd, ad * bn);
         OP_LT, OP_GT, OP_LE, OP_GE: begin
            if (ad == 0 || bd == 0) begin
               r.cmp = (ad == 0 && bd == 0);
            end else begin
               if (ad < 0) begin
                  an = -an;
                  ad = -ad;
               end
               lhs = an * bd;
               rhs = bn * ad;
               case (op)
                  OP_LT: r.cmp = lhs < rhs;
                  OP_GT: r.cmp = lhs > rhs;
                  OP_LE: r.cmp = lhs <= rhs;
                  default: r.cmp = lhs >= rhs;
               endcase
            end
         end
         OP_EQ: begin
            ra = reduce_signed(an, ad);
            rb = reduce_signed(bn, bd);
            r.cmp = ra.num == rb.num && ra.den == rb.den && ra.ovf == rb.ovf;
            // When either side overflows, the unreduced cross products decide.
            if (ra.ovf || rb.ovf)
               r.cmp = ((ad == 0) == (bd == 0)) && (an * bd == bn * ad);
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      frac_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (fraction_queue.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[31:0], '0);
            end else begin
               want = fraction_queue.pop_front();
               if (rsp_tdata[31:0] !== want.num)
                  report_mismatch("result_num", rsp_tdata[31:0], want.num);
               if (rsp_tdata[62:32] !== want.den)
                  report_mismatch("result_den", 32'(rsp_tdata[62:32]), 32'(want.den));
               if (rsp_tdata[63] !== want.cmp)
                  report_mismatch("compare_true", 32'(rsp_tdata[63]), 32'(want.cmp));
               if (rsp_tuser[0] !== want.ovf)
                  report_mismatch("overflow", 32'(rsp_tuser[0]), 32'(want.ovf));
            end
            result_index++;
         end
         if (req_tvalid && req_tready)
            fraction_queue.insert(fraction_queue.size(),
                                  predict_fraction(req_tuser, req_tdata));
      end
   end

endmodule

>>> sim/rational_arithmetic_unit_test.sv
`timescale 1ns / 1ps
module rational_arithmetic_unit_test import rau_pkg::*;;

   localparam int RANDOM_ITEMS = 1450;
   localparam int CYCLE_LIMIT  = 2000000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic [3:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   int           mismatch_count;
   int           outstanding;
   int           items_sent;
   int           cycle_count;
   bit           sender_bursty;

   rational_arithmetic_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   rational_arithmetic_unit_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .mismatch_count(mismatch_count), .outstanding(outstanding)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL rational_arithmetic_unit");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [3:0] op, input logic [31:0] an, input logic [31:0] ad,
                            input logic [31:0] bn, input logic [30:0] bd);
      int gap;
      gap = sender_bursty ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {1'b0, bd, bn, ad, an};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Mix of small values, extremes and full-width random words.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0, 1, 2: return 32'($signed($urandom_range(0, 40)) - 20);
         3: return 32'h8000_0000;
         4: return 32'h7fff_ffff;
         5: return 32'($urandom_range(0, 2)) - 32'd1;
         6: return 32'(1) << $urandom_range(0, 31);
         7: return 32'($urandom_range(0, 1000)) * 32'($urandom_range(0, 1000));
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [3:0] op;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_MAKE;
      items_sent = 0;
      sender_bursty = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_MAKE, 32'd6, -32'sd4, 32'd0, 31'd1);
      send_item(OP_MAKE, 32'd0, -32'sd7, 32'd0, 31'd1);
      send_item(OP_MAKE, -32'sd5, 32'd0, 32'd0, 31'd1);
      send_item(OP_MAKE, 32'd0, 32'd0, 32'd0, 31'd1);
      // The most negative numerator over -1 does not fit.
      send_item(OP_MAKE, 32'h8000_0000, -32'sd1, 32'd0, 31'd1);
      send_item(OP_MAKE, 32'h8000_0000, 32'h8000_0000, 32'd0, 31'd1);
      send_item(OP_ADD, 32'd1, 32'd2, 32'd1, 31'd3);
      send_item(OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 31'd1);
      send_item(OP_SUB, 32'd1, 32'd2, 32'd1, 31'd2);
      send_item(OP_SUB, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 31'h7fff_ffff);
      send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff);
      send_item(OP_MUL, -32'sd3, 32'd4, 32'd4, 31'd3);
      send_item(OP_DIV, 32'd1, 32'd2, 32'd0, 31'd5);
      send_item(OP_DIV, 32'd3, 32'd0, 32'd2, 31'd0);
      send_item(OP_LT, 32'd1, 32'd3, 32'd1, 31'd2);
      send_item(OP_GT, 32'd1, -32'sd3, 32'd1, 31'd2);
      send_item(OP_LE, 32'd1, 32'd2, 32'd2, 31'd4);
      send_item(OP_GE, 32'd1, 32'd0, 32'd5, 31'd0);
      send_item(OP_LT, 32'd1, 32'd0, 32'd5, 31'd3);
      send_item(OP_EQ, 32'd1, 32'd0, 32'd2, 31'd0);
      send_item(OP_EQ, -32'sd1, 32'd0, 32'd2, 31'd0);
      send_item(OP_EQ, 32'd0, 32'd0, 32'd0, 31'd0);
      send_item(OP_EQ, 32'h8000_0000, -32'sd1, 32'h8000_0000, 31'h7fff_ffff);
      send_item(OP_EQ, -32'sd2, -32'sd4, 32'd1, 31'd2);
      send_item(4'd13, $urandom, $urandom, $urandom, 31'($urandom));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) sender_bursty = ($urandom_range(0, 3) == 0);
         op = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
         send_item(op, pick_word(), ($urandom_range(0, 15) == 0) ? 32'd0 : pick_word(),
                   pick_word(), ($urandom_range(0, 15) == 0) ? 31'd0 : 31'(pick_word()));
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("PASS rational_arithmetic_unit");
      else
         $display("FAIL rational_arithmetic_unit");
      $finish;
   end

   initial begin
      int  stall;
      int  taken;
      bit  long_hold_done;
      bit  receiver_bursty;
      rsp_tready = 1'b0;
      taken = 0;
      long_hold_done = 0;
      receiver_bursty = 0;
      @(negedge reset);
      forever begin
         if (taken % 80 == 0) receiver_bursty = ($urandom_range(0, 3) == 0);
         stall = receiver_bursty ? 0 : $urandom_range(0, 11);
         // One long hold-off while the sender keeps offering items.
         if (!long_hold_done && items_sent > 100) begin
            stall = 600;
            long_hold_done = 1;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
      end
   end

endmodule
